### rtl/bone_palette_partitioner_macros.svh
// ----------------------------------------------------------------------------
// Bone palette partitioner assertion macros
// Shared concurrent assertion helpers, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef BONE_PALETTE_PARTITIONER_MACROS_SVH
`define BONE_PALETTE_PARTITIONER_MACROS_SVH

// same-cycle implication
`define BPP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bone palette partitioner check failed");

// next-cycle implication
`define BPP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bone palette partitioner check failed");

`endif

### rtl/bpp_pkg.sv
// ----------------------------------------------------------------------------
// bpp_pkg
// Constants, command and status types shared by the partitioner modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpp_pkg;

    localparam int PALETTE_SIZE_DEF    = 32;
    localparam int BONE_TABLE_SIZE_DEF = 256;

    localparam int MAX_NEW      = 12;   // bone references per face
    localparam int FACE_W       = 16;
    localparam int IDX_W        = 18;
    localparam int MESH_W       = 8;
    localparam int BONE_W       = 8;
    localparam int VB_W         = 32;
    localparam int VALID_W      = 6;
    localparam int SLOT_W       = 5;
    localparam int TB_W         = 8;
    localparam int NEW_W        = 4;
    localparam int SU_W         = 6;
    localparam int IN_TDATA_W   = 120;
    localparam int OUT_TDATA_W  = 64;

    localparam logic [BONE_W-1:0] DUMMY_BONE = 8'hFF;

    // kind of palette run being emitted
    typedef enum logic [1:0] {
        EM_IDENT,
        EM_CLOSE,
        EM_LAST
    } t_emit;

    typedef struct packed {
        logic  ram_clr;
        logic  load;
        logic  alloc_clr;
        logic  gth_start;
        logic  gth_run;
        logic  commit;
        logic  emit_start;
        t_emit emit_mode;
        logic  emit_run;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic tb_zero;
        logic tb_small;
        logic last;
        logic overflow;
        logic gth_done;
        logic commit_done;
        logic emit_done;
    } t_status;

endpackage

### rtl/bpp_ram.sv
// ----------------------------------------------------------------------------
// bpp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpp_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/bpp_ctrl.sv
// ----------------------------------------------------------------------------
// bpp_ctrl
// Sequencer: clear pass, accept, gather, overflow close, commit, emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bone_palette_partitioner_macros.svh"

module bpp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  bpp_pkg::t_status i_status,
    output bpp_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_MODE,
        S_GATHER,
        S_CHECK,
        S_COMMIT,
        S_CLOSE,
        S_EMIT
    } t_state;

    t_state         r_state;
    t_state         n_state;
    bpp_pkg::t_emit r_mode;

    // command decode
    always_comb begin
        o_cmd           = '0;
        o_cmd.emit_mode = bpp_pkg::EM_LAST;
        n_state         = r_state;
        case (r_state)
            S_CLR: begin
                o_cmd.ram_clr = 1'b1;
                if (i_status.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.load = 1'b1;
                if (i_in_valid) n_state = S_MODE;
            end
            S_MODE: begin
                if (i_status.tb_zero) begin
                    n_state = S_IDLE;
                end else if (i_status.tb_small) begin
                    if (i_status.last) begin
                        o_cmd.emit_start = 1'b1;
                        o_cmd.emit_mode  = bpp_pkg::EM_IDENT;
                        n_state          = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.gth_start = 1'b1;
                    n_state         = S_GATHER;
                end
            end
            S_GATHER: begin
                o_cmd.gth_run = 1'b1;
                if (i_status.gth_done) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.overflow) begin
                    o_cmd.emit_start = 1'b1;
                    o_cmd.emit_mode  = bpp_pkg::EM_CLOSE;
                    n_state          = S_EMIT;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                if (i_status.commit_done) n_state = S_CLOSE;
            end
            S_CLOSE: begin
                if (i_status.last) begin
                    o_cmd.emit_start = 1'b1;
                    o_cmd.emit_mode  = bpp_pkg::EM_LAST;
                    n_state          = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                o_cmd.emit_run = 1'b1;
                if (i_status.emit_done) begin
                    if (r_mode == bpp_pkg::EM_CLOSE) begin
                        // retry the face on a fresh palette
                        o_cmd.alloc_clr = 1'b1;
                        o_cmd.gth_start = 1'b1;
                        n_state         = S_GATHER;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_mode  <= bpp_pkg::EM_LAST;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit_start) r_mode <= o_cmd.emit_mode;
        end
    end

    `BPP_ASSERT_NEXT(a_accept_to_mode, (r_state == S_IDLE) && i_in_valid, r_state == S_MODE)

endmodule

### rtl/bpp_datapath.sv
// ----------------------------------------------------------------------------
// bpp_datapath
// Bone-to-slot lookup, palette allocation, commit and palette run output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bone_palette_partitioner_macros.svh"

module bpp_datapath #(
    parameter int PALETTE_SIZE    = bpp_pkg::PALETTE_SIZE_DEF,
    parameter int BONE_TABLE_SIZE = bpp_pkg::BONE_TABLE_SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bpp_pkg::t_cmd                     i_cmd,
    output bpp_pkg::t_status                  o_status,
    input  logic                              i_cfg_valid,
    input  logic [bpp_pkg::TB_W-1:0]          i_cfg_data,
    input  logic                              i_s_tvalid,
    input  logic [bpp_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  logic [0:0]                        i_s_tuser,
    input  logic                              i_s_tlast,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [bpp_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic                              o_m_tlast
);

    localparam int ADDR_W = $clog2(BONE_TABLE_SIZE);
    localparam int CNT_W  = $clog2(BONE_TABLE_SIZE + 1);
    localparam int STD    = PALETTE_SIZE - 1;
    localparam int STW    = $clog2(PALETTE_SIZE - 1);
    localparam int SLW    = $clog2(PALETTE_SIZE);
    localparam int FRW    = $clog2(bpp_pkg::MAX_NEW);
    localparam int SU_W   = bpp_pkg::SU_W;
    localparam int NEW_W  = bpp_pkg::NEW_W;
    localparam int BONE_W = bpp_pkg::BONE_W;

    // item registers
    logic [bpp_pkg::TB_W-1:0]     r_tb;
    logic [bpp_pkg::FACE_W-1:0]   r_face;
    logic                         r_last;
    logic [bpp_pkg::MESH_W-1:0]   r_mesh;
    logic [3*bpp_pkg::VB_W-1:0]   r_vb;

    // allocation state
    logic [bpp_pkg::FACE_W-1:0]   r_start;
    logic [SU_W-1:0]              r_su;
    logic [NEW_W-1:0]             r_n;
    logic [BONE_W-1:0]            r_stb   [STD];
    logic [BONE_W-1:0]            r_fresh [bpp_pkg::MAX_NEW];

    // gather pipeline
    logic [NEW_W-1:0]             r_gk;
    logic                         r_chk_v;
    logic [BONE_W-1:0]            r_chk_b;
    logic                         r_fw_v;
    logic [BONE_W-1:0]            r_fw_b;
    logic [SU_W-1:0]              r_fw_val;
    logic [NEW_W-1:0]             r_cj;
    logic [CNT_W-1:0]             r_clr_cnt;

    // emission
    logic [bpp_pkg::FACE_W-1:0]   r_e_start;
    logic [bpp_pkg::FACE_W:0]     r_e_faces;
    logic [bpp_pkg::VALID_W-1:0]  r_e_valid;
    logic                         r_e_ident;
    logic [bpp_pkg::MESH_W-1:0]   r_e_mesh;
    logic [SLW-1:0]               r_e_s;

    // output register
    logic                         r_o_valid;
    logic [bpp_pkg::IDX_W-1:0]    r_o_start;
    logic [bpp_pkg::IDX_W-1:0]    r_o_count;
    logic [bpp_pkg::MESH_W-1:0]   r_o_mesh;
    logic [bpp_pkg::VALID_W-1:0]  r_o_vslots;
    logic [bpp_pkg::SLOT_W-1:0]   r_o_slot;
    logic [BONE_W-1:0]            r_o_bone;
    logic                         r_o_last;

    logic                         load;
    logic                         alloc_clr;
    logic                         clr_done;
    logic [NEW_W-1:0]             gk_idx;
    logic [BONE_W-1:0]            gth_byte;
    logic [SU_W-1:0]              ram_rdata;
    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    logic [SU_W-1:0]              ram_wdata;
    logic [SU_W-1:0]              v;
    logic [SU_W-1:0]              j;
    logic [STW-1:0]               stb_idx;
    logic [BONE_W-1:0]            stb_rd;
    logic [NEW_W-1:0]             fr_idx;
    logic [BONE_W-1:0]            fr_rd;
    logic                         in_tbl;
    logic                         mapped_lo;
    logic                         mapped_hi;
    logic                         is_new;
    logic [SU_W-1:0]              new_slot;
    logic [SU_W-1:0]              cs;
    logic                         commit_done;
    logic                         load_o;
    logic [bpp_pkg::FACE_W-1:0]   diff;
    logic [BONE_W-1:0]            bone_e;

    assign load      = i_cmd.load && i_s_tvalid;
    assign alloc_clr = i_cmd.alloc_clr || (load && i_s_tuser[0]);
    assign clr_done  = (r_clr_cnt == CNT_W'(BONE_TABLE_SIZE));

    // bone byte to look up this cycle
    assign gk_idx   = (r_gk < NEW_W'(bpp_pkg::MAX_NEW)) ? r_gk : '0;
    assign gth_byte = r_vb[{gk_idx, 3'b000} +: BONE_W];

    // slot lookup, forwarded from the write of the previous cycle
    assign v        = (r_fw_v && (r_fw_b == r_chk_b)) ? r_fw_val : ram_rdata;
    assign j        = v - r_su;
    assign stb_idx  = i_cmd.emit_run ? r_e_s[STW-1:0] : v[STW-1:0];
    assign stb_rd   = (32'(stb_idx) < STD) ? r_stb[stb_idx] : bpp_pkg::DUMMY_BONE;
    assign fr_idx   = i_cmd.commit ? r_cj : ((j < SU_W'(r_n)) ? j[NEW_W-1:0] : '0);
    assign fr_rd    = (fr_idx < NEW_W'(bpp_pkg::MAX_NEW)) ? r_fresh[fr_idx[FRW-1:0]] : '0;

    // a stored slot counts only if the inverse table points back at the bone
    assign in_tbl    = ({1'b0, r_chk_b} < 9'(BONE_TABLE_SIZE));
    assign mapped_lo = (v < r_su) && (stb_rd == r_chk_b);
    assign mapped_hi = (v >= r_su) && (j < SU_W'(r_n)) && (fr_rd == r_chk_b);
    assign is_new    = i_cmd.gth_run && r_chk_v && in_tbl && !mapped_lo && !mapped_hi
                       && (r_n < NEW_W'(bpp_pkg::MAX_NEW));
    assign new_slot  = r_su + SU_W'(r_n);

    // table RAM: clearing pass, then lookup writes
    assign ram_we    = i_cmd.ram_clr ? !clr_done : is_new;
    assign ram_waddr = i_cmd.ram_clr ? r_clr_cnt[ADDR_W-1:0] : r_chk_b[ADDR_W-1:0];
    assign ram_wdata = i_cmd.ram_clr ? '0 : new_slot;

    bpp_ram #(
        .WIDTH (SU_W),
        .DEPTH (BONE_TABLE_SIZE)
    ) u_bone_to_slot (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (gth_byte[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign cs          = r_su + SU_W'(r_cj);
    assign commit_done = (r_cj == r_n);

    // emission entry
    assign load_o = i_cmd.emit_run && (!r_o_valid || i_m_tready);
    assign diff   = r_face - r_start;
    always_comb begin
        if (r_e_ident) begin
            bone_e = (BONE_W'(r_e_s) < r_tb) ? BONE_W'(r_e_s) : bpp_pkg::DUMMY_BONE;
        end else begin
            bone_e = (32'(r_e_s) < STD) ? stb_rd : bpp_pkg::DUMMY_BONE;
        end
    end

    // status
    assign o_status.clr_done    = clr_done;
    assign o_status.tb_zero     = (r_tb == '0);
    assign o_status.tb_small    = ({1'b0, r_tb} < 9'(PALETTE_SIZE));
    assign o_status.last        = r_last;
    assign o_status.overflow    = ({1'b0, r_su} + 7'(r_n)) > 7'(PALETTE_SIZE - 1);
    assign o_status.gth_done    = (r_gk == NEW_W'(bpp_pkg::MAX_NEW)) && !r_chk_v;
    assign o_status.commit_done = commit_done;
    assign o_status.emit_done   = (!r_o_valid || i_m_tready) && (32'(r_e_s) == STD);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tb      <= '0;
            r_start   <= '0;
            r_su      <= '0;
            r_n       <= '0;
            r_gk      <= '0;
            r_chk_v   <= 1'b0;
            r_fw_v    <= 1'b0;
            r_cj      <= '0;
            r_clr_cnt <= '0;
            r_e_s     <= '0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < STD; i++) r_stb[i] <= bpp_pkg::DUMMY_BONE;
        end else begin
            if (i_cfg_valid) r_tb <= i_cfg_data;
            if (i_cmd.ram_clr && !clr_done) r_clr_cnt <= r_clr_cnt + 1'b1;

            if (alloc_clr) begin
                r_su    <= '0;
                r_start <= load ? i_s_tdata[bpp_pkg::FACE_W-1:0] : r_face;
                for (int i = 0; i < STD; i++) r_stb[i] <= bpp_pkg::DUMMY_BONE;
            end

            if (i_cmd.gth_start) begin
                r_gk    <= '0;
                r_n     <= '0;
                r_cj    <= '0;
                r_chk_v <= 1'b0;
                r_fw_v  <= 1'b0;
            end else if (i_cmd.gth_run) begin
                r_chk_v <= (r_gk < NEW_W'(bpp_pkg::MAX_NEW));
                if (r_gk < NEW_W'(bpp_pkg::MAX_NEW)) r_gk <= r_gk + 1'b1;
                r_fw_v <= is_new;
                if (is_new) r_n <= r_n + 1'b1;
            end

            // copy the new bones into the palette, one a cycle
            if (i_cmd.commit) begin
                if (!commit_done) begin
                    r_cj <= r_cj + 1'b1;
                    if (32'(cs) < STD) r_stb[cs[STW-1:0]] <= fr_rd;
                end else begin
                    r_su <= r_su + SU_W'(r_n);
                end
            end

            if (i_cmd.emit_start) begin
                r_e_s <= '0;
            end else if (load_o) begin
                r_e_s <= r_e_s + 1'b1;
            end

            if (load_o) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_face <= i_s_tdata[15:0];
            r_mesh <= i_s_tdata[23:16];
            r_vb   <= i_s_tdata[119:24];
            r_last <= i_s_tlast;
        end
        if (i_cmd.gth_run && (r_gk < NEW_W'(bpp_pkg::MAX_NEW))) begin
            r_chk_b <= gth_byte;
        end
        if (is_new) begin
            r_fresh[r_n[FRW-1:0]] <= r_chk_b;
            r_fw_b                <= r_chk_b;
            r_fw_val              <= new_slot;
        end
        if (i_cmd.emit_start) begin
            r_e_start <= r_start;
            r_e_mesh  <= r_mesh;
            r_e_ident <= (i_cmd.emit_mode == bpp_pkg::EM_IDENT);
            if (i_cmd.emit_mode == bpp_pkg::EM_CLOSE) begin
                r_e_faces <= {1'b0, diff};
            end else begin
                r_e_faces <= {1'b0, diff} + 17'd1;
            end
            if (i_cmd.emit_mode == bpp_pkg::EM_IDENT) begin
                r_e_valid <= r_tb[bpp_pkg::VALID_W-1:0] + 1'b1;
            end else begin
                r_e_valid <= r_su + 1'b1;
            end
        end
        if (load_o) begin
            r_o_start  <= {2'b00, r_e_start} + {1'b0, r_e_start, 1'b0};
            r_o_count  <= {1'b0, r_e_faces} + {r_e_faces, 1'b0};
            r_o_mesh   <= r_e_mesh;
            r_o_vslots <= r_e_valid;
            r_o_slot   <= bpp_pkg::SLOT_W'(r_e_s);
            r_o_bone   <= bone_e;
            r_o_last   <= (32'(r_e_s) == STD);
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tlast  = r_o_last;
    assign o_m_tdata  = {1'b0, r_o_bone, r_o_slot, r_o_vslots, r_o_mesh, r_o_count, r_o_start};

    `BPP_ASSERT_NOW(a_su_bound, 1'b1, r_su <= SU_W'(PALETTE_SIZE - 1))
    `BPP_ASSERT_NOW(a_new_bound, 1'b1, r_n <= NEW_W'(bpp_pkg::MAX_NEW))
    `BPP_ASSERT_NOW(a_run_end, r_o_valid, r_o_last == (32'(r_o_slot) == STD))

endmodule

### rtl/bone_palette_partitioner.sv
// Per face, accept to next accept: accept, mode check, a lookup pass over 12 bones,
//   overflow check, commit of the new bones, close.
// Identity or zero mode: accept and mode check. A closed submesh adds a run of
//   PALETTE_SIZE results; an overflow close adds one run plus a second lookup pass.
// Reset: synchronous, active low; then a clearing pass over the bone table RAM,
//   with tready low. Config writes are taken at any time.
// ----------------------------------------------------------------------------
// bone_palette_partitioner
// Splits skinned mesh faces into submeshes with bounded bone palettes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bone_palette_partitioner #(
    parameter int PALETTE_SIZE    = bpp_pkg::PALETTE_SIZE_DEF,
    parameter int BONE_TABLE_SIZE = bpp_pkg::BONE_TABLE_SIZE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration: total_bones
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bpp_pkg::TB_W-1:0]        i_cfg_data,
    // face requests
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // face_number, source_mesh, vertex0_bones, vertex1_bones, vertex2_bones
    input  logic [bpp_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // first_face
    input  logic [0:0]                      i_s_axis_tuser,
    input  logic                            i_s_axis_tlast,     // last_face
    // palette entries
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // index_start, index_count, mesh_of_origin, valid_slots, slot, bone, zero pad
    output logic [bpp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                            o_m_axis_tlast      // run_end
);

    bpp_pkg::t_cmd    cmd;
    bpp_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    bpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bpp_datapath #(
        .PALETTE_SIZE    (PALETTE_SIZE),
        .BONE_TABLE_SIZE (BONE_TABLE_SIZE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_axis_tvalid),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .i_s_tlast   (i_s_axis_tlast),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tlast   (o_m_axis_tlast)
    );

endmodule

### sim/bone_palette_partitioner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bone_palette_partitioner_tb
// Drives triangles with random bone sets through the partitioner, predicts
// each palette entry from a local model of the slot allocation, and checks
// every result field in order under random idling on both streams.
// ----------------------------------------------------------------------------

module bone_palette_partitioner_tb;

    localparam int PAL       = bpp_pkg::PALETTE_SIZE_DEF;
    localparam int TBL       = bpp_pkg::BONE_TABLE_SIZE_DEF;
    localparam int WDOG_LIMIT = 20000;
    localparam int SETTLE    = 200;

    typedef struct packed {
        logic [17:0] index_start;
        logic [17:0] index_count;
        logic [7:0]  mesh_of_origin;
        logic [5:0]  valid_slots;
        logic [4:0]  slot;
        logic [7:0]  bone;
        logic        run_end;
    } t_entry;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [bpp_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic [0:0]  i_s_axis_tuser;
    logic        i_s_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [bpp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    bone_palette_partitioner dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // predictor state
    logic [5:0]  bone_slot [TBL];
    logic [7:0]  slot_bone [PAL-1];
    int unsigned used_slots;
    logic [15:0] start_face;
    logic [7:0]  bone_count;

    t_entry      palette_q [$];
    int          errors;
    int          idle_cycles;
    logic        hold_off;
    int unsigned hold_len;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog on cycles with no handshake on any stream
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void clear_alloc();
        for (int i = 0; i < TBL; i++) bone_slot[i] = 6'(PAL);
        for (int i = 0; i < PAL - 1; i++) slot_bone[i] = bpp_pkg::DUMMY_BONE;
        used_slots = 0;
    endfunction

    function automatic void push_run(logic [15:0] sf, logic [17:0] faces, logic [7:0] mesh,
                                     int unsigned valid, bit ident);
        t_entry e;
        for (int s = 0; s < PAL; s++) begin
            e.index_start    = 18'(sf * 3);
            e.index_count    = 18'(faces * 3);
            e.mesh_of_origin = mesh;
            e.valid_slots    = 6'(valid);
            e.slot           = 5'(s);
            if (ident) e.bone = (s < bone_count) ? 8'(s) : bpp_pkg::DUMMY_BONE;
            else       e.bone = (s < PAL - 1) ? slot_bone[s] : bpp_pkg::DUMMY_BONE;
            e.run_end        = (s == PAL - 1);
            palette_q.insert(palette_q.size(), e);
        end
    endfunction

    // tentative mapping of the face's unseen bones
    function automatic int unsigned map_fresh(logic [31:0] vb [3], ref logic [7:0] fresh [12]);
        int unsigned n;
        logic [7:0] b;
        n = 0;
        for (int v = 0; v < 3; v++)
            for (int k = 0; k < 4; k++) begin
                b = vb[v][8*k +: 8];
                if (b < TBL && bone_slot[b] == 6'(PAL) && n < bpp_pkg::MAX_NEW) begin
                    fresh[n] = b;
                    bone_slot[b] = 6'(used_slots + n);
                    n++;
                end
            end
        return n;
    endfunction

    function automatic void predict_face(logic [15:0] face, bit first, bit last,
                                         logic [7:0] mesh, logic [31:0] vb [3]);
        logic [7:0]  fresh [12];
        int unsigned n;
        logic [15:0] diff;
        if (first) begin
            clear_alloc();
            start_face = face;
        end
        if (bone_count == 0) return;
        if (bone_count < PAL) begin
            diff = face - start_face;
            if (last) push_run(start_face, 18'(diff) + 18'd1, mesh, bone_count + 1, 1'b1);
            return;
        end
        n = map_fresh(vb, fresh);
        if (used_slots + n > PAL - 1) begin
            diff = face - start_face;
            for (int j = 0; j < n; j++) bone_slot[fresh[j]] = 6'(PAL);
            push_run(start_face, 18'(diff), mesh, used_slots + 1, 1'b0);
            clear_alloc();
            start_face = face;
            n = map_fresh(vb, fresh);
        end
        for (int j = 0; j < n; j++)
            if (used_slots + j < PAL - 1) slot_bone[used_slots + j] = fresh[j];
        used_slots += n;
        if (last) begin
            diff = face - start_face;
            push_run(start_face, 18'(diff) + 18'd1, mesh, used_slots + 1, 1'b0);
        end
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int unsigned gap;
        i_m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                i_m_axis_tready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_off = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (gap != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk iff o_m_axis_tvalid);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_entry got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tdata[62:0], o_m_axis_tlast};
            got.run_end = o_m_axis_tlast;
            got.index_start    = o_m_axis_tdata[17:0];
            got.index_count    = o_m_axis_tdata[35:18];
            got.mesh_of_origin = o_m_axis_tdata[43:36];
            got.valid_slots    = o_m_axis_tdata[49:44];
            got.slot           = o_m_axis_tdata[54:50];
            got.bone           = o_m_axis_tdata[62:55];
            if (palette_q.size() == 0) begin
                $error("unexpected palette entry %h", o_m_axis_tdata);
                errors++;
            end else begin
                want = palette_q.pop_front();
                if (got.index_start != want.index_start) begin
                    $error("index_start exp %0d got %0d", want.index_start, got.index_start);
                    errors++;
                end
                if (got.index_count != want.index_count) begin
                    $error("index_count exp %0d got %0d", want.index_count, got.index_count);
                    errors++;
                end
                if (got.mesh_of_origin != want.mesh_of_origin) begin
                    $error("mesh_of_origin exp %0d got %0d", want.mesh_of_origin,
                           got.mesh_of_origin);
                    errors++;
                end
                if (got.valid_slots != want.valid_slots) begin
                    $error("valid_slots exp %0d got %0d", want.valid_slots, got.valid_slots);
                    errors++;
                end
                if (got.slot != want.slot) begin
                    $error("slot exp %0d got %0d", want.slot, got.slot);
                    errors++;
                end
                if (got.bone != want.bone) begin
                    $error("bone exp %0d got %0d", want.bone, got.bone);
                    errors++;
                end
                if (got.run_end != want.run_end) begin
                    $error("run_end exp %0d got %0d", want.run_end, got.run_end);
                    errors++;
                end
            end
        end
    end

    // one face request; gap drawn per item unless told otherwise
    task automatic send_face(logic [15:0] face, bit first, bit last, logic [7:0] mesh,
                             logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
                             bit no_gap = 0);
        logic [31:0] vb [3];
        int unsigned gap;
        vb[0] = v0; vb[1] = v1; vb[2] = v2;
        gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {v2, v1, v0, mesh, face};
        i_s_axis_tuser  <= first;
        i_s_axis_tlast  <= last;
        @(posedge i_clk iff o_s_axis_tready);
        predict_face(face, first, last, mesh, vb);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (palette_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // register write only once every face has left the block
    task automatic write_bones(logic [7:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk iff o_cfg_ready);
        i_cfg_valid <= 1'b0;
        bone_count = value;
    endtask

    function automatic logic [31:0] rand_bones(int unsigned span);
        logic [31:0] r;
        for (int k = 0; k < 4; k++) r[8*k +: 8] = 8'($urandom_range(0, span));
        return r;
    endfunction

    // random mesh of well-formed faces, bones from a limited range
    task automatic random_mesh(int unsigned faces, int unsigned span, bit no_gap = 0);
        logic [15:0] f;
        logic [7:0]  m;
        f = 16'($urandom);
        m = 8'($urandom);
        for (int i = 0; i < faces; i++)
            send_face(f + 16'(i), i == 0, i == faces - 1, m,
                      rand_bones(span), rand_bones(span), rand_bones(span), no_gap);
    endtask

    task automatic test_zero_bones();
        send_face(16'd5, 1, 0, 8'd1, 32'h0302_0100, 32'hFFFF_FFFF, 32'h0, 0);
        send_face(16'd6, 0, 1, 8'd1, 32'h0807_0605, 32'h0, 32'h0, 0);
        drain();
    endtask

    task automatic test_identity();
        write_bones(8'd1);
        send_face(16'hFFFF, 1, 1, 8'hFF, 32'hFFFF_FFFF, 32'h0, 32'h1234_5678);
        write_bones(8'd31);
        send_face(16'd10, 1, 0, 8'd3, 32'h0, 32'h0, 32'h0);
        send_face(16'd4, 0, 1, 8'd3, 32'h0, 32'h0, 32'h0);   // face number wraps back
        send_face(16'd20, 0, 1, 8'd0, 32'h0, 32'h0, 32'h0);  // continues without first
        drain();
    endtask

    task automatic test_palette_directed();
        write_bones(8'd255);
        send_face(16'd0, 1, 1, 8'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_face(16'd100, 1, 0, 8'd7, 32'h0302_0100, 32'h0706_0504, 32'h0B0A_0908);
        send_face(16'd101, 0, 0, 8'd7, 32'h0F0E_0D0C, 32'h1312_1110, 32'h1716_1514);
        send_face(16'd102, 0, 0, 8'd7, 32'h1B1A_1918, 32'h1F1E_1D1C, 32'h2322_2120);
        send_face(16'd103, 0, 1, 8'd7, 32'hFFFE_FDFC, 32'h0100_FFFE, 32'h0000_0000);
        send_face(16'd104, 0, 1, 8'd8, 32'h5555_AAAA, 32'h0, 32'h0);  // after last face
        write_bones(8'd32);
        send_face(16'hFFF0, 1, 0, 8'd9, 32'h0302_0100, 32'h0706_0504, 32'h0B0A_0908);
        send_face(16'hFFF1, 0, 0, 8'd9, 32'h0302_0100, 32'h0706_0504, 32'h0B0A_0908);
        send_face(16'd2, 0, 1, 8'd9, 32'h0F0E_0D0C, 32'h1312_1110, 32'h1716_1514);
        drain();
    endtask

    task automatic test_random();
        write_bones(8'd255);
        repeat (30) random_mesh($urandom_range(1, 12), $urandom_range(8, 255));
        drain();
        write_bones(8'($urandom_range(1, 31)));
        repeat (5) random_mesh($urandom_range(1, 6), 255);
        drain();
        write_bones(8'($urandom_range(32, 254)));
        for (int i = 0; i < 30; i++)
            send_face(16'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0,
                      8'($urandom), $urandom, $urandom, $urandom);
        repeat (6) random_mesh($urandom_range(2, 10), $urandom_range(20, 80));
        drain();
    endtask

    // receiver stalls for a long stretch while faces keep coming
    task automatic test_backpressure();
        hold_len = 600;
        hold_off = 1'b1;
        repeat (3) random_mesh(3, 60, 1);
        drain();
    endtask

    initial begin
        errors          = 0;
        idle_cycles     = 0;
        hold_off        = 1'b0;
        hold_len        = 0;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_s_axis_tlast  = 1'b0;
        clear_alloc();
        start_face = '0;
        bone_count = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_bones();
        test_identity();
        test_palette_directed();
        test_random();
        test_backpressure();

        if (errors == 0 && palette_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
